FILE: rtl/fpit_pkg.sv
// Package for the in-flight pixel scoreboard: action codes, sequencer states
// and IEEE single compare helpers. No dependencies.
`default_nettype none
package fpit_pkg;

    localparam int unsigned FuncIssue = 0;

    typedef enum logic [2:0] {
        ACT_NEW_PUSH   = 3'd0,
        ACT_RETRY_PUSH = 3'd1,
        ACT_PLOT       = 3'd2,
        ACT_POOL_FULL  = 3'd3,
        ACT_NO_MATCH   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_CHECK,
        ST_WRITE,
        ST_OUT
    } t_state;

    localparam logic [31:0] ThresholdReset = 32'h4080_0000;

    function automatic logic f_is_nan(input logic [31:0] b);
        return b[30:0] > 31'h7f80_0000;
    endfunction

    function automatic logic f_is_inf(input logic [31:0] b);
        return b[30:0] == 31'h7f80_0000;
    endfunction

    // IEEE equality: NaN never equal, signed zeros equal
    function automatic logic f_eq(input logic [31:0] a, input logic [31:0] b);
        logic r;
        r = 1'b0;
        if (!f_is_nan(a) && !f_is_nan(b)) begin
            if (a[30:0] == 31'd0 && b[30:0] == 31'd0) r = 1'b1;
            else r = (a == b);
        end
        return r;
    endfunction

    // monotone key, zeros folded
    function automatic logic [31:0] f_key(input logic [31:0] b);
        logic [31:0] v;
        v = (b[30:0] == 31'd0) ? 32'd0 : b;
        return v[31] ? ~v : (v | 32'h8000_0000);
    endfunction

    function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
        return !f_is_nan(a) && !f_is_nan(b) && (f_key(a) > f_key(b));
    endfunction

endpackage
`default_nettype wire

FILE: rtl/fpit_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module fpit_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // registered read, old data returned on a write to the same address
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/fractal_pixel_inflight_tracker.sv
// In-flight pixel scoreboard, top level: slot RAM, valid bits and the
// scanning sequencer. Depends on fpit_pkg and fpit_ram.
//
// Usage: an input word (func, pixel, coordinates, result) is taken on
// i_valid && !o_stall. An issue word claims the lowest free slot and answers
// with a new push (colour zero); a completion word walks the slots from 0,
// reading them one at a time from the slot RAM through a shared IEEE compare,
// and stops at the first valid slot with equal coordinates. The answer is a
// plot (slot freed) or a retry push; no free slot or no match gives an error
// word. One result word follows each input word on o_valid.
// One word at a time: o_stall is high from acceptance until the result is
// taken, and the next word can be taken the cycle after.
// Reset (i_rst_n low, synchronous) clears all valid bits and the count and
// sets the threshold to 4.0. While i_stall is high the result is held stable.
// The threshold is written on i_cfg_valid && o_cfg_ready, always ready.
`default_nettype none
module fractal_pixel_inflight_tracker #(
    parameter int unsigned SLOTS      = 255,
    parameter int unsigned ITER_LIMIT = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [9:0]  i_pixel_col,
    input  wire logic [8:0]  i_pixel_row,
    input  wire logic [31:0] i_coord_real,
    input  wire logic [31:0] i_coord_imag,
    input  wire logic [31:0] i_engine_result,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_action,
    output logic [9:0]       o_out_col,
    output logic [8:0]       o_out_row,
    output logic [7:0]       o_colour,
    output logic [7:0]       o_slot_used,
    output logic [7:0]       o_in_flight,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_escape_threshold
);
    localparam int unsigned IW = $clog2(SLOTS);
    localparam int unsigned CW = $clog2(ITER_LIMIT + 1);
    localparam int unsigned TW = $clog2(SLOTS + 1);
    localparam int unsigned DW = 10 + 9 + 32 + 32 + CW;
    localparam logic [IW-1:0] LastSlot = IW'(SLOTS - 1);

    fpit_pkg::t_state r_state, n_state;
    logic [SLOTS-1:0] r_vld;
    logic [TW-1:0]    r_total;
    logic [31:0]      r_thr;
    logic [IW-1:0]    r_idx;
    logic             r_func;
    logic [9:0]       r_col;
    logic [8:0]       r_row;
    logic [31:0]      r_re, r_im, r_res;
    logic             r_ovalid;
    logic [2:0]       r_act;
    logic [9:0]       r_ocol;
    logic [8:0]       r_orow;
    logic [7:0]       r_colour;
    logic [CW-1:0]    r_cnt;

    logic          ram_we;
    logic [IW-1:0] ram_addr;
    logic [DW-1:0] ram_wdata, ram_rdata;
    logic [9:0]    rd_col;
    logic [8:0]    rd_row;
    logic [31:0]   rd_re, rd_im;
    logic [CW-1:0] rd_cnt, cnt_inc;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic          hit, done_plot;

    assign {rd_col, rd_row, rd_re, rd_im, rd_cnt} = ram_rdata;
    assign cnt_inc = rd_cnt + CW'(1);

    // an issue writes straight into the free slot, otherwise the scan index
    assign ram_addr = (r_state == fpit_pkg::ST_SCAN && r_func == 1'(fpit_pkg::FuncIssue))
                      ? free_idx : r_idx;

    fpit_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // lowest free slot (priority over valid bits)
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_vld[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // shared compare on the slot just read
    assign hit = r_vld[r_idx] && fpit_pkg::f_eq(rd_re, r_re)
                 && fpit_pkg::f_eq(rd_im, r_im);
    assign done_plot = (32'(cnt_inc) >= 32'(ITER_LIMIT))
                       || fpit_pkg::f_gt(r_res, r_thr) || fpit_pkg::f_is_inf(r_res);

    assign o_stall     = (r_state != fpit_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_action    = r_act;
    assign o_out_col   = r_ocol;
    assign o_out_row   = r_orow;
    assign o_colour    = r_colour;
    assign o_slot_used = 8'(r_idx);
    assign o_in_flight = 8'(r_total);

    // next state
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_wdata = {rd_col, rd_row, rd_re, rd_im, r_cnt};
        case (r_state)
            fpit_pkg::ST_IDLE: begin
                if (i_valid) n_state = fpit_pkg::ST_SCAN;
            end
            fpit_pkg::ST_SCAN: begin
                if (r_func == 1'(fpit_pkg::FuncIssue)) begin
                    ram_we    = free_found;
                    ram_wdata = {r_col, r_row, r_re, r_im, CW'(0)};
                    n_state   = fpit_pkg::ST_OUT;
                end else begin
                    n_state = fpit_pkg::ST_WAIT;
                end
            end
            fpit_pkg::ST_WAIT:  n_state = fpit_pkg::ST_CHECK;
            fpit_pkg::ST_CHECK: begin
                if (hit) n_state = fpit_pkg::ST_WRITE;
                else if (r_idx == LastSlot) n_state = fpit_pkg::ST_OUT;
                else n_state = fpit_pkg::ST_WAIT;
            end
            fpit_pkg::ST_WRITE: begin
                ram_we  = 1'b1;
                n_state = fpit_pkg::ST_OUT;
            end
            fpit_pkg::ST_OUT: begin
                if (!i_stall) n_state = fpit_pkg::ST_IDLE;
            end
            default: n_state = fpit_pkg::ST_IDLE;
        endcase
    end

    // state, valid bits, count, threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fpit_pkg::ST_IDLE;
            r_vld    <= '0;
            r_total  <= '0;
            r_thr    <= fpit_pkg::ThresholdReset;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_thr <= i_cfg_escape_threshold;
            case (r_state)
                fpit_pkg::ST_SCAN: begin
                    if (r_func == 1'(fpit_pkg::FuncIssue)) begin
                        r_ovalid <= 1'b1;
                        if (free_found) begin
                            r_vld[free_idx] <= 1'b1;
                            r_total         <= r_total + TW'(1);
                        end
                    end
                end
                fpit_pkg::ST_CHECK: begin
                    if (!hit && r_idx == LastSlot) r_ovalid <= 1'b1;
                end
                fpit_pkg::ST_WRITE: begin
                    r_ovalid <= 1'b1;
                    if (r_act == fpit_pkg::ACT_PLOT) begin
                        r_vld[r_idx] <= 1'b0;
                        r_total      <= r_total - TW'(1);
                    end
                end
                fpit_pkg::ST_OUT: begin
                    if (!i_stall) r_ovalid <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            fpit_pkg::ST_IDLE: begin
                r_func <= i_func;
                r_col  <= i_pixel_col;
                r_row  <= i_pixel_row;
                r_re   <= i_coord_real;
                r_im   <= i_coord_imag;
                r_res  <= i_engine_result;
                r_idx  <= '0;
            end
            fpit_pkg::ST_SCAN: begin
                if (r_func == 1'(fpit_pkg::FuncIssue)) begin
                    r_colour <= '0;
                    if (free_found) begin
                        r_idx  <= free_idx;
                        r_act  <= fpit_pkg::ACT_NEW_PUSH;
                        r_ocol <= r_col;
                        r_orow <= r_row;
                    end else begin
                        r_idx  <= '0;
                        r_act  <= fpit_pkg::ACT_POOL_FULL;
                        r_ocol <= '0;
                        r_orow <= '0;
                    end
                end
            end
            fpit_pkg::ST_CHECK: begin
                if (hit) begin
                    r_cnt  <= cnt_inc;
                    r_ocol <= rd_col;
                    r_orow <= rd_row;
                    if (done_plot) begin
                        r_act    <= fpit_pkg::ACT_PLOT;
                        r_colour <= 8'(cnt_inc);
                    end else begin
                        r_act    <= fpit_pkg::ACT_RETRY_PUSH;
                        r_colour <= '0;
                    end
                end else if (r_idx == LastSlot) begin
                    r_idx    <= '0;
                    r_act    <= fpit_pkg::ACT_NO_MATCH;
                    r_ocol   <= '0;
                    r_orow   <= '0;
                    r_colour <= '0;
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for fractal_pixel_inflight_tracker: drives issue and
// completion words, predicts each answer and compares field by field.
// Depends on fpit_pkg and the scoreboard RTL.
`timescale 1ns / 1ps
module tb_top;

    localparam int NSLOT = 255;
    localparam int ITER_MAX = 256;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic        func;
        logic [9:0]  col;
        logic [8:0]  row;
        logic [31:0] re;
        logic [31:0] im;
        logic [31:0] res;
    } t_word;

    typedef struct packed {
        fpit_pkg::t_action act;
        logic [9:0]  col;
        logic [8:0]  row;
        logic [7:0]  colour;
        logic [7:0]  slot;
        logic [7:0]  in_flight;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_func = 1'b0;
    logic [9:0] i_pixel_col = '0;
    logic [8:0] i_pixel_row = '0;
    logic [31:0] i_coord_real = '0;
    logic [31:0] i_coord_imag = '0;
    logic [31:0] i_engine_result = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [2:0] o_action;
    logic [9:0] o_out_col;
    logic [8:0] o_out_row;
    logic [7:0] o_colour;
    logic [7:0] o_slot_used;
    logic [7:0] o_in_flight;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [31:0] i_cfg_escape_threshold = '0;

    fractal_pixel_inflight_tracker dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic        pm_valid [NSLOT];
    logic [9:0]  pm_col [NSLOT];
    logic [8:0]  pm_row [NSLOT];
    logic [31:0] pm_re [NSLOT];
    logic [31:0] pm_im [NSLOT];
    int unsigned pm_count [NSLOT];
    int unsigned pm_total;
    logic [31:0] pm_threshold;

    t_word   pending_words [$];
    t_answer expected_answers [$];
    // coordinates of pixels thought to be in flight, for well-formed reports
    logic [63:0] live_coords [$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  hold_rx = 1'b0;

    function automatic bit fp_nan(logic [31:0] b);
        return b[30:0] > 31'h7f80_0000;
    endfunction

    function automatic bit fp_same(logic [31:0] a, logic [31:0] b);
        if (fp_nan(a) || fp_nan(b)) return 1'b0;
        if (a[30:0] == 0 && b[30:0] == 0) return 1'b1;
        return a == b;
    endfunction

    function automatic logic [31:0] fp_order(logic [31:0] b);
        logic [31:0] v;
        v = (b[30:0] == 0) ? 32'd0 : b;
        return v[31] ? ~v : (v | 32'h8000_0000);
    endfunction

    // work out the scoreboard's answer to one word and update its slots
    function automatic t_answer score_word(t_word w);
        t_answer a;
        int i;
        bit escaped;
        a = '0;
        if (w.func == fpit_pkg::FuncIssue) begin
            for (i = 0; i < NSLOT; i++) if (!pm_valid[i]) break;
            if (i == NSLOT) a.act = fpit_pkg::ACT_POOL_FULL;
            else begin
                pm_valid[i] = 1'b1; pm_col[i] = w.col; pm_row[i] = w.row;
                pm_re[i] = w.re; pm_im[i] = w.im; pm_count[i] = 0;
                pm_total++;
                a.act = fpit_pkg::ACT_NEW_PUSH; a.col = w.col; a.row = w.row;
                a.slot = i[7:0];
            end
        end else begin
            for (i = 0; i < NSLOT; i++)
                if (pm_valid[i] && fp_same(pm_re[i], w.re) && fp_same(pm_im[i], w.im)) break;
            if (i == NSLOT) a.act = fpit_pkg::ACT_NO_MATCH;
            else begin
                pm_count[i]++;
                a.col = pm_col[i]; a.row = pm_row[i]; a.slot = i[7:0];
                escaped = !fp_nan(w.res) && !fp_nan(pm_threshold)
                    && fp_order(w.res) > fp_order(pm_threshold);
                if (pm_count[i] >= ITER_MAX || escaped || w.res[30:0] == 31'h7f80_0000) begin
                    a.act = fpit_pkg::ACT_PLOT; a.colour = pm_count[i][7:0];
                    pm_valid[i] = 1'b0; pm_total--;
                end else a.act = fpit_pkg::ACT_RETRY_PUSH;
            end
        end
        a.in_flight = pm_total[7:0];
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_float();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7fc0_0000 | $urandom_range(0, 255);
            3: return $urandom_range(0, 1) ? 32'h7f80_0000 : 32'hff80_0000;
            4: return $urandom;
            default: return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 140)),
                             23'($urandom)};
        endcase
    endfunction

    function automatic t_word issue_word(logic [31:0] re, logic [31:0] im);
        t_word w;
        w.func = 1'b0;
        w.col = 10'($urandom_range(0, 639)); w.row = 9'($urandom_range(0, 479));
        w.re = re; w.im = im; w.res = $urandom;
        return w;
    endfunction

    function automatic t_word report_word(logic [31:0] re, logic [31:0] im,
                                          logic [31:0] res);
        t_word w;
        w = '0; w.func = 1'b1; w.re = re; w.im = im; w.res = res;
        w.col = 10'($urandom); w.row = 9'($urandom_range(0, 479));
        return w;
    endfunction

    // result magnitude: mostly below the limit so pixels retry a while
    function automatic logic [31:0] pick_result();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return {1'b0, 8'($urandom_range(100, 128)), 23'($urandom)};
        if (r < 85) return {1'b0, 8'($urandom_range(129, 254)), 23'($urandom)};
        if (r < 90) return 32'hff80_0000;
        if (r < 94) return 32'h7f80_0000;
        if (r < 97) return 32'hffc0_0001;
        return $urandom;
    endfunction

    // accepted-word flag sampled at the rising edge
    bit tx_taken = 1'b0;
    always @(posedge i_clk) begin
        tx_taken <= i_rst_n && i_valid && !o_stall;
    end

    // driver: decides at the falling edge from the last rising-edge sample
    int tx_wait = 0;
    always @(negedge i_clk) begin
        t_word w;
        if (i_rst_n) begin
            if (i_valid && !tx_taken) begin
                // word still waiting, keep it
            end else if (tx_wait > 0) begin
                i_valid <= 1'b0;
                tx_wait <= tx_wait - 1;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                expected_answers.push_back(score_word(w));
                i_valid <= 1'b1;
                i_func <= w.func; i_pixel_col <= w.col; i_pixel_row <= w.row;
                i_coord_real <= w.re; i_coord_imag <= w.im; i_engine_result <= w.res;
                tx_wait <= pick_gap();
            end else i_valid <= 1'b0;
        end
    end

    // receiver back-pressure, with a long hold-off when asked
    int rx_wait = 0;
    always @(negedge i_clk) begin
        if (hold_rx) i_stall <= 1'b1;
        else if (rx_wait > 0) begin
            i_stall <= 1'b1;
            rx_wait <= rx_wait - 1;
        end else begin
            i_stall <= 1'b0;
            rx_wait <= pick_gap();
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_answer e;
        if (!i_rst_n) idle_cycles <= 0;
        else begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || pending_words.size() == 0
                && expected_answers.size() == 0 || hold_rx)
                idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall) begin
                if (expected_answers.size() == 0) begin
                    $error("unexpected result word, action %0d", o_action);
                    errors++;
                end else begin
                    e = expected_answers.pop_front();
                    if (o_action !== e.act) begin
                        $error("action: expected %0d, got %0d", e.act, o_action);
                        errors++;
                    end
                    if (o_out_col !== e.col) begin
                        $error("out_col: expected %0d, got %0d", e.col, o_out_col);
                        errors++;
                    end
                    if (o_out_row !== e.row) begin
                        $error("out_row: expected %0d, got %0d", e.row, o_out_row);
                        errors++;
                    end
                    if (o_colour !== e.colour) begin
                        $error("colour: expected %0d, got %0d", e.colour, o_colour);
                        errors++;
                    end
                    if (o_slot_used !== e.slot) begin
                        $error("slot_used: expected %0d, got %0d", e.slot, o_slot_used);
                        errors++;
                    end
                    if (o_in_flight !== e.in_flight) begin
                        $error("in_flight: expected %0d, got %0d", e.in_flight, o_in_flight);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic drain();
        wait (pending_words.size() == 0);
        @(posedge i_clk);
        while (i_valid || expected_answers.size() != 0) @(posedge i_clk);
        repeat (2 * NSLOT + 20) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [31:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_escape_threshold <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        pm_threshold = v;
    endtask

    // a batch of pixel lifetimes with random content, mixed with stray reports
    task automatic queue_traffic(int count);
        int n;
        int k;
        logic [63:0] c;
        for (n = 0; n < count; n++) begin
            k = $urandom_range(0, 99);
            if (k < 35 && live_coords.size() < 40 || live_coords.size() == 0) begin
                c = {pick_float(), pick_float()};
                if (k < 3) c = live_coords.size() ? live_coords[0] : c;
                pending_words.push_back(issue_word(c[63:32], c[31:0]));
                if (!fp_nan(c[63:32]) && !fp_nan(c[31:0])) live_coords.push_back(c);
            end else if (k < 92) begin
                k = $urandom_range(0, live_coords.size() - 1);
                c = live_coords[k];
                if ($urandom_range(0, 1)) begin
                    // the other signed zero still matches
                    if (c[62:32] == 0) c[63] = ~c[63];
                    if (c[30:0] == 0) c[31] = ~c[31];
                end
                pending_words.push_back(report_word(c[63:32], c[31:0], pick_result()));
                if ($urandom_range(0, 5) == 0) live_coords.delete(k);
            end else
                pending_words.push_back(report_word(pick_float(), pick_float(), $urandom));
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < NSLOT; i++) begin
            pm_valid[i] = 1'b0; pm_count[i] = 0;
        end
        pm_total = 0;
        pm_threshold = fpit_pkg::ThresholdReset;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zeros, NaN, infinities, iteration limit
        pending_words.push_back(report_word(32'h3f80_0000, 32'h0, 32'h0));
        pending_words.push_back(issue_word(32'h0000_0000, 32'h8000_0000));
        pending_words[$].col = 639; pending_words[$].row = 479;
        pending_words.push_back(issue_word(32'h7fc0_0000, 32'h3f80_0000));
        pending_words[$].col = 0; pending_words[$].row = 0;
        pending_words.push_back(issue_word(32'hffff_ffff, 32'h7f7f_ffff));
        pending_words.push_back(report_word(32'h8000_0000, 32'h0000_0000, 32'h7fc0_0000));
        pending_words.push_back(report_word(32'h7fc0_0000, 32'h3f80_0000, 32'h0));
        pending_words.push_back(report_word(32'hffff_ffff, 32'h7f7f_ffff, 32'h4080_0000));
        pending_words.push_back(report_word(32'hffff_ffff, 32'h7f7f_ffff, 32'h4080_0001));
        pending_words.push_back(report_word(32'h0, 32'h0, 32'hff80_0000));
        pending_words.push_back(issue_word(32'h1234_5678, 32'h0));
        pending_words.push_back(report_word(32'h1234_5678, 32'h0, 32'h7f80_0000));
        pending_words.push_back(issue_word(32'h4000_0000, 32'hc000_0000));
        for (i = 0; i < ITER_MAX; i++)
            pending_words.push_back(report_word(32'h4000_0000, 32'hc000_0000, 32'h0));
        drain();

        // fill the pool to overflow; results are held back at the start
        hold_rx = 1'b1;
        for (i = 0; i < NSLOT + 3; i++)
            pending_words.push_back(issue_word($urandom, i));
        repeat (200) @(posedge i_clk);
        hold_rx = 1'b0;
        drain();
        for (i = NSLOT - 1; i >= 0; i--)
            if (pm_valid[i])
                pending_words.push_back(report_word(pm_re[i], pm_im[i], 32'h7f80_0000));
        drain();

        // random phases under several thresholds, extremes among them
        live_coords.delete();
        queue_traffic(100); drain();
        write_threshold(32'h0000_0000);
        queue_traffic(60); drain();
        write_threshold(32'hffff_ffff);
        queue_traffic(60); drain();
        write_threshold(32'h7f80_0000);
        queue_traffic(40); drain();
        write_threshold($urandom);
        queue_traffic(40); drain();
        write_threshold(fpit_pkg::ThresholdReset);
        queue_traffic(30); drain();

        if (errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end
endmodule
